// File: src/sbmc_pkg.sv
// Shared types, constants and helper functions for the stepper blind motion controller.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sbmc_pkg;

	// Travel geometry.
	localparam int FULL_TRAVEL    = 4910;
	localparam int SLOWDOWN_STEPS = 100;
	localparam logic signed [15:0] FULL_TRAVEL_S = 16'(FULL_TRAVEL);
	localparam logic signed [15:0] SLOW_NEAR_TOP = 16'(FULL_TRAVEL - SLOWDOWN_STEPS);
	localparam logic signed [15:0] SLOW_NEAR_BOTTOM = 16'(SLOWDOWN_STEPS);
	localparam logic [7:0] SLOWDOWN_INIT = 8'(SLOWDOWN_STEPS);

	// Fixed timing.
	localparam logic [16:0] CFG_PHASE_US  = 17'd3000;
	localparam logic [31:0] SETUP_LOCK_US = 32'd100000;

	// Reciprocal for position * 100 / FULL_TRAVEL. Rounding up with this shift makes
	// the truncated product exact for every dividend below 2^22.
	localparam int PCT_SHIFT = 37;
	localparam logic [63:0] PCT_RECIP =
		((64'd1 << PCT_SHIFT) + 64'(FULL_TRAVEL) - 64'd1) / 64'(FULL_TRAVEL);

	// Item actions.
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_UP   = 2'd1;
	localparam logic [1:0] ACT_DOWN = 2'd2;
	localparam logic [1:0] ACT_LOAD = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_CONFIGURE_MODE = 3'd0;
	localparam logic [2:0] CFG_REVERSED       = 3'd1;
	localparam logic [2:0] CFG_UP_LOW         = 3'd2;
	localparam logic [2:0] CFG_UP_HIGH        = 3'd3;
	localparam logic [2:0] CFG_DOWN_LOW       = 3'd4;
	localparam logic [2:0] CFG_DOWN_HIGH      = 3'd5;
	localparam logic [2:0] CFG_EXTRA_LOW      = 3'd6;
	localparam logic [2:0] CFG_HOLD_LOCK      = 3'd7;

	// Reported mode codes.
	localparam logic [1:0] MODE_CODE_STOPPED = 2'd0;
	localparam logic [1:0] MODE_CODE_HOLD    = 2'd1;
	localparam logic [1:0] MODE_CODE_SETUP   = 2'd2;
	localparam logic [1:0] MODE_CODE_RUNNING = 2'd3;

	// Position classes.
	localparam logic [1:0] CLASS_CLOSED = 2'd0;
	localparam logic [1:0] CLASS_OPEN   = 2'd1;
	localparam logic [1:0] CLASS_AJAR   = 2'd2;

	typedef enum logic [3:0] {
		MODE_STOPPED = 4'b0001,
		MODE_HOLD    = 4'b0010,
		MODE_SETUP   = 4'b0100,
		MODE_RUNNING = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        now_us;
		logic signed [15:0] load_distance;
	} cmd_item_t;

	typedef struct packed {
		logic               step_level;
		logic               dir_level;
		logic               motor_enable;
		logic [1:0]         mode_code;
		logic signed [15:0] travel;
		logic [6:0]         open_percent;
		logic [1:0]         position_class;
		logic               save_strobe;
		logic               idle;
	} res_item_t;

	typedef struct packed {
		logic        configure_mode;
		logic        reversed;
		logic [15:0] up_low_us;
		logic [15:0] up_high_us;
		logic [15:0] down_low_us;
		logic [15:0] down_high_us;
		logic [15:0] extra_low_us;
		logic [23:0] hold_lock_us;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [31:0]        mode_time;
		logic [31:0]        phase_time;
		logic               step_phase;
		logic               moving_up;
		logic signed [15:0] position;
		logic [7:0]         slowdown_left;
		logic               step_out;
		logic               dir_pin;
		logic               motor_on;
	} motion_state_t;

	function automatic logic [1:0] mode_code_of(input mode_t m);
		logic [1:0] code;
		unique case (m)
			MODE_STOPPED: code = MODE_CODE_STOPPED;
			MODE_HOLD:    code = MODE_CODE_HOLD;
			MODE_SETUP:   code = MODE_CODE_SETUP;
			MODE_RUNNING: code = MODE_CODE_RUNNING;
			default:      code = MODE_CODE_STOPPED;
		endcase
		return code;
	endfunction

	// Opening in percent: zero at or below closed, full at or above full travel,
	// otherwise the truncated quotient through the reciprocal multiply.
	function automatic logic [6:0] percent_of(input logic signed [15:0] pos);
		logic [21:0] scaled;
		logic [52:0] prod;
		logic [6:0]  pct;
		scaled = ({7'd0, pos[14:0]} << 6) + ({7'd0, pos[14:0]} << 5)
			+ ({7'd0, pos[14:0]} << 2);
		prod = {31'd0, scaled} * {22'd0, PCT_RECIP[30:0]};
		if (pos <= 16'sd0) begin
			pct = 7'd0;
		end else if (pos >= FULL_TRAVEL_S) begin
			pct = 7'd100;
		end else begin
			pct = prod[PCT_SHIFT+6:PCT_SHIFT];
		end
		return pct;
	endfunction

endpackage

`default_nettype wire

// File: src/stepper_blind_motion_controller.sv
// Top level of the stepper blind motion controller: handshake, state and result registers.
// Depends on sbmc_pkg, sbmc_cfg and sbmc_core.
//
// Usage. Items enter on the cmd channel (cmd_valid, cmd_stall, cmd) and are either
// time ticks with a microsecond timestamp, pull up or pull down commands, or a load
// of a stored position. Every item yields exactly one result item on the res channel
// (res_valid, res_stall, res), carrying the step, direction and motor enable pin
// levels, the mode, the position with its percent and class, the save strobe and
// the idle flag. An item is taken at a clock edge where valid is high and stall low.
// The item is captured in the input register, then the updated motion state and the
// result are registered together. Throughput is one item per cycle while res_stall is
// low; the core's next-state logic and percent reciprocal multiply are combinational
// and so allow that rate, since each item depends on the state the previous one left.
// While the receiver stalls, the result register holds, the input register keeps one
// more item, and cmd_stall rises only when both are full. Reset, asynchronous and
// active low, leaves the block stopped with the motor unpowered, the position at zero
// and the state, valid and configuration registers at their defaults. The user must
// write configuration registers through cfg_we, cfg_index and cfg_data only while the
// block is idle (not enforced by the block); they take effect on the items that follow.
`timescale 1ns / 1ps
`default_nettype none

module stepper_blind_motion_controller (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [23:0]         cfg_data,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire sbmc_pkg::cmd_item_t cmd,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output sbmc_pkg::res_item_t      res
);
	import sbmc_pkg::*;

	cfg_t          cfg;
	motion_state_t state_q;
	motion_state_t state_next;
	res_item_t     res_next;

	cmd_item_t cmd_s1;
	logic      valid_s1;
	res_item_t res_s2;
	logic      valid_s2;

	logic advance;
	logic fire;

	sbmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbmc_core u_core (
		.cfg (cfg),
		.st  (state_q),
		.cmd (cmd_s1),
		.ns  (state_next),
		.res (res_next)
	);

	// The captured item moves on whenever the result register is empty or being read.
	assign advance   = !valid_s2 || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	// Motion state commits together with the result of the item that produced it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_STOPPED;
			state_q.mode_time     <= 32'd0;
			state_q.phase_time    <= 32'd0;
			state_q.step_phase    <= 1'b0;
			state_q.moving_up     <= 1'b0;
			state_q.position      <= 16'sd0;
			state_q.slowdown_left <= 8'd0;
			state_q.step_out      <= 1'b0;
			state_q.dir_pin       <= 1'b0;
			state_q.motor_on      <= 1'b0;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

// File: src/sbmc_cfg.sv
// Configuration register file of the stepper blind motion controller.
// Depends on sbmc_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module sbmc_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [23:0]   cfg_data,
	output sbmc_pkg::cfg_t     cfg
);
	import sbmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.configure_mode <= 1'b0;
			cfg_q.reversed       <= 1'b0;
			cfg_q.up_low_us      <= 16'd1800;
			cfg_q.up_high_us     <= 16'd1000;
			cfg_q.down_low_us    <= 16'd900;
			cfg_q.down_high_us   <= 16'd800;
			cfg_q.extra_low_us   <= 16'd1000;
			cfg_q.hold_lock_us   <= 24'd3000000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONFIGURE_MODE: cfg_q.configure_mode <= cfg_data[0];
				CFG_REVERSED:       cfg_q.reversed       <= cfg_data[0];
				CFG_UP_LOW:         cfg_q.up_low_us      <= cfg_data[15:0];
				CFG_UP_HIGH:        cfg_q.up_high_us     <= cfg_data[15:0];
				CFG_DOWN_LOW:       cfg_q.down_low_us    <= cfg_data[15:0];
				CFG_DOWN_HIGH:      cfg_q.down_high_us   <= cfg_data[15:0];
				CFG_EXTRA_LOW:      cfg_q.extra_low_us   <= cfg_data[15:0];
				CFG_HOLD_LOCK:      cfg_q.hold_lock_us   <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: src/sbmc_core.sv
// Next-state and result logic of the stepper blind motion controller for one item.
// Depends on sbmc_pkg for the item, state and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module sbmc_core (
	input  wire sbmc_pkg::cfg_t          cfg,
	input  wire sbmc_pkg::motion_state_t st,
	input  wire sbmc_pkg::cmd_item_t     cmd,
	output sbmc_pkg::motion_state_t      ns,
	output sbmc_pkg::res_item_t          res
);
	import sbmc_pkg::*;

	logic        near_end;
	logic        extra_on;
	logic [16:0] low_us;
	logic [15:0] high_us;
	logic [31:0] interval;
	logic [31:0] mode_elapsed;
	logic [31:0] phase_elapsed;
	logic        tick_may_move;

	// Phase lengths and limits from the state before the item; a tick does not
	// change direction or position before these are consulted.
	always_comb begin
		near_end = (st.position > SLOW_NEAR_TOP) || (st.position < SLOW_NEAR_BOTTOM);
		extra_on = near_end || (st.moving_up && (st.slowdown_left != 8'd0));
		if (cfg.configure_mode) begin
			low_us  = CFG_PHASE_US;
			high_us = CFG_PHASE_US[15:0];
		end else begin
			low_us = {1'b0, st.moving_up ? cfg.up_low_us : cfg.down_low_us}
				+ {1'b0, extra_on ? cfg.extra_low_us : 16'd0};
			high_us = st.moving_up ? cfg.up_high_us : cfg.down_high_us;
		end
		interval = st.step_phase ? {16'd0, high_us} : {15'd0, low_us};
		mode_elapsed  = cmd.now_us - st.mode_time;
		phase_elapsed = cmd.now_us - st.phase_time;
		tick_may_move = cfg.configure_mode
			|| (st.moving_up ? (st.position < FULL_TRAVEL_S) : (st.position > 16'sd0));
	end

	logic up_cmd;
	logic turn;
	logic cmd_may_move;
	logic save;

	always_comb begin
		ns   = st;
		save = 1'b0;
		up_cmd = (cmd.action == ACT_UP);
		turn = (st.moving_up != up_cmd);
		cmd_may_move = cfg.configure_mode
			|| (up_cmd ? (st.position < FULL_TRAVEL_S) : (st.position > 16'sd0));
		unique case (cmd.action)
			ACT_UP, ACT_DOWN: begin
				ns.moving_up = up_cmd;
				if (cmd_may_move && ((st.mode == MODE_STOPPED) || (st.mode == MODE_HOLD)
						|| ((st.mode == MODE_RUNNING) && turn))) begin
					ns.slowdown_left = SLOWDOWN_INIT;
					ns.mode          = MODE_SETUP;
					ns.mode_time     = cmd.now_us;
					ns.motor_on      = 1'b1;
				end
			end
			ACT_LOAD: begin
				ns.position = cmd.load_distance;
			end
			ACT_TICK: begin
				if ((st.mode == MODE_HOLD) && (mode_elapsed > {8'd0, cfg.hold_lock_us})) begin
					ns.motor_on  = 1'b0;
					ns.mode      = MODE_STOPPED;
					ns.mode_time = cmd.now_us;
				end
				if ((st.mode == MODE_SETUP) && (mode_elapsed > SETUP_LOCK_US)) begin
					ns.mode      = MODE_RUNNING;
					ns.mode_time = cmd.now_us;
				end
				if (ns.mode == MODE_RUNNING) begin
					if (tick_may_move) begin
						if (phase_elapsed > interval) begin
							ns.phase_time = cmd.now_us;
							ns.dir_pin    = st.moving_up ^ cfg.reversed;
							ns.step_out   = st.step_phase;
							// A step is counted on the rising edge of the step pin.
							if (st.step_phase) begin
								if (st.moving_up) begin
									if (st.position != 16'sh7fff) begin
										ns.position = st.position + 16'sd1;
									end
								end else if (st.position != -16'sh8000) begin
									ns.position = st.position - 16'sd1;
								end
							end
							ns.step_phase = ~st.step_phase;
							if (st.slowdown_left != 8'd0) begin
								ns.slowdown_left = st.slowdown_left - 8'd1;
							end
						end
					end else begin
						ns.mode       = MODE_HOLD;
						ns.mode_time  = cmd.now_us;
						ns.step_phase = 1'b0;
						ns.step_out   = 1'b0;
						ns.dir_pin    = 1'b0;
						if (cfg.configure_mode) begin
							ns.position = 16'sd0;
						end
						save = 1'b1;
					end
				end
			end
		endcase
	end

	always_comb begin
		res.step_level   = ns.step_out;
		res.dir_level    = ns.dir_pin;
		res.motor_enable = ns.motor_on;
		res.mode_code    = mode_code_of(ns.mode);
		res.travel       = ns.position;
		res.open_percent = percent_of(ns.position);
		if (ns.position == 16'sd0) begin
			res.position_class = CLASS_CLOSED;
		end else if (ns.position == FULL_TRAVEL_S) begin
			res.position_class = CLASS_OPEN;
		end else begin
			res.position_class = CLASS_AJAR;
		end
		res.save_strobe = save;
		res.idle        = (ns.mode == MODE_STOPPED) && !cfg.configure_mode;
	end

endmodule

`default_nettype wire
